// ===== design/sac_lru_pkg.sv =====
// Shared geometry, field widths and tag store row layout for the
// set-associative LRU lookup. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sac_lru_pkg;

    // Cache geometry (sizes are powers of two)
    localparam int CACHE_BYTES = 65536;
    localparam int BLOCK_BYTES = 32;
    localparam int WAYS        = 4;

    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int WAY_OUT_W = 4;

    localparam int SETS_RAW = CACHE_BYTES / (BLOCK_BYTES * WAYS);
    localparam int SETS     = (SETS_RAW > 0) ? SETS_RAW : 1;

    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int SET_W  = $clog2(SETS);
    localparam int IDX_W  = (SET_W > 0) ? SET_W : 1;
    localparam int TAG_W  = ADDR_W - OFF_W - SET_W;
    localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'(SETS - 1);

    // One way of a set: valid, tag and recency stamp
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_way;

    // One memory row holds a whole set
    typedef t_way [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

endpackage

`default_nettype wire

// ===== design/set_assoc_cache_lru_lookup_unit.sv =====
// Set-associative tag lookup with LRU replacement; uses sac_lru_pkg, sac_lru_ram.
// A beat is first read from the set memory, then looked up and written back as its result loads.
// A new beat is not taken until the previous one has left the look state and loaded its result.
// Reset (i_rst_n low, synchronous) clears the counters and starts a clearing pass over
// every row of the set memory (SETS rows, 512 at the default geometry); o_stall stays high
// for that pass.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_lru_lookup_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_req_type,
    input  wire logic [sac_lru_pkg::ADDR_W-1:0]      i_address,
    input  wire logic [sac_lru_pkg::STAMP_W-1:0]     i_time_stamp,
    // output channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_miss,
    output logic [sac_lru_pkg::WAY_OUT_W-1:0]        o_way_used,
    output logic [sac_lru_pkg::CNT_W-1:0]            o_hit_total,
    output logic [sac_lru_pkg::CNT_W-1:0]            o_miss_total,
    output logic [sac_lru_pkg::CNT_W-1:0]            o_load_hit_total,
    output logic [sac_lru_pkg::CNT_W-1:0]            o_load_miss_total
);

    // Two-state sequencer: idle waits for a beat, look holds the set read
    // data until the result register is free.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    localparam logic [sac_lru_pkg::CNT_W-1:0] CNT_MAX = '1;

    logic r_state, n_state;

    // Clearing pass after reset
    logic                          r_clr_busy;
    logic [sac_lru_pkg::IDX_W-1:0] r_clr_idx;

    // Request held while its set is looked up
    logic                          r_is_load;
    logic [sac_lru_pkg::IDX_W-1:0] r_set;
    logic [sac_lru_pkg::TAG_W-1:0] r_tag;
    logic [sac_lru_pkg::STAMP_W-1:0] r_stamp;

    // Result register; the counters themselves are the count outputs
    logic                              r_out_valid;
    logic                              r_miss;
    logic [sac_lru_pkg::WAY_OUT_W-1:0] r_way;
    logic [sac_lru_pkg::CNT_W-1:0]     r_hit_cnt, r_miss_cnt, r_ld_hit_cnt, r_ld_miss_cnt;

    logic in_accept;
    logic look_fire;

    // Memory port signals
    logic                          mem_we;
    logic [sac_lru_pkg::IDX_W-1:0] mem_waddr;
    logic [sac_lru_pkg::ROW_W-1:0] mem_wdata;
    logic [sac_lru_pkg::IDX_W-1:0] mem_raddr;
    logic [sac_lru_pkg::ROW_W-1:0] mem_rdata;

    sac_lru_pkg::t_row rd_row;
    sac_lru_pkg::t_row wr_row;

    // Lookup results
    logic                           hit;
    logic                           found_hit;
    logic [sac_lru_pkg::WAY_IW-1:0] hit_way;
    logic                           found_free;
    logic [sac_lru_pkg::WAY_IW-1:0] free_way;
    logic [sac_lru_pkg::WAY_IW-1:0] lru_way;
    logic [sac_lru_pkg::STAMP_W-1:0] lru_best;
    logic [sac_lru_pkg::WAY_IW-1:0] sel_way;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    // A new beat is taken only in idle and after the clearing pass; the
    // result register may still hold an older result waiting downstream.
    assign o_stall   = r_clr_busy || (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;

    // Look completes once the result register can take the new result.
    assign look_fire = (r_state == S_LOOK) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (look_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Set memory: one row per set, all ways side by side
    // ------------------------------------------------------------------
    assign mem_raddr = sac_lru_pkg::IDX_W'((i_address >> sac_lru_pkg::OFF_W)
                                           & sac_lru_pkg::SET_MASK);
    assign mem_we    = r_clr_busy || look_fire;
    assign mem_waddr = r_clr_busy ? r_clr_idx : r_set;
    assign mem_wdata = r_clr_busy ? '0 : wr_row;

    sac_lru_ram #(
        .WIDTH (sac_lru_pkg::ROW_W),
        .DEPTH (sac_lru_pkg::SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_accept),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_row = sac_lru_pkg::t_row'(mem_rdata);

    // ------------------------------------------------------------------
    // Lookup on the row read for the held request
    // ------------------------------------------------------------------
    always_comb begin
        found_hit  = 1'b0;
        hit_way    = '0;
        found_free = 1'b0;
        free_way   = '0;
        lru_best   = rd_row[0].stamp;
        lru_way    = '0;
        for (int w = 0; w < sac_lru_pkg::WAYS; w++) begin
            // first valid way with a matching tag
            if (!found_hit && rd_row[w].valid && (rd_row[w].tag == r_tag)) begin
                found_hit = 1'b1;
                hit_way   = sac_lru_pkg::WAY_IW'(w);
            end
            // first empty way
            if (!found_free && !rd_row[w].valid) begin
                found_free = 1'b1;
                free_way   = sac_lru_pkg::WAY_IW'(w);
            end
        end
        // running minimum of stamps, strict compare keeps the lowest way on ties
        for (int w = 1; w < sac_lru_pkg::WAYS; w++) begin
            if (rd_row[w].stamp < lru_best) begin
                lru_best = rd_row[w].stamp;
                lru_way  = sac_lru_pkg::WAY_IW'(w);
            end
        end
    end

    assign hit = found_hit;

    always_comb begin
        priority if (found_hit) begin
            sel_way = hit_way;
        end else if (found_free) begin
            sel_way = free_way;
        end else begin
            sel_way = lru_way;
        end
    end

    always_comb begin
        wr_row                = rd_row;
        wr_row[sel_way].valid = 1'b1;
        wr_row[sel_way].tag   = r_tag;
        wr_row[sel_way].stamp = r_stamp;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_clr_busy    <= 1'b1;
            r_clr_idx     <= '0;
            r_out_valid   <= 1'b0;
            r_hit_cnt     <= '0;
            r_miss_cnt    <= '0;
            r_ld_hit_cnt  <= '0;
            r_ld_miss_cnt <= '0;
        end else begin
            r_state <= n_state;

            if (r_clr_busy) begin
                if (r_clr_idx == sac_lru_pkg::IDX_W'(sac_lru_pkg::SETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_idx <= r_clr_idx + 1'b1;
            end

            if (look_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            // counters move only when a new result is loaded
            if (look_fire) begin
                if (hit) begin
                    if (r_hit_cnt != CNT_MAX) begin
                        r_hit_cnt <= r_hit_cnt + 1'b1;
                    end
                    if (r_is_load && (r_ld_hit_cnt != CNT_MAX)) begin
                        r_ld_hit_cnt <= r_ld_hit_cnt + 1'b1;
                    end
                end else begin
                    if (r_miss_cnt != CNT_MAX) begin
                        r_miss_cnt <= r_miss_cnt + 1'b1;
                    end
                    if (r_is_load && (r_ld_miss_cnt != CNT_MAX)) begin
                        r_ld_miss_cnt <= r_ld_miss_cnt + 1'b1;
                    end
                end
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_is_load <= !i_req_type;
            r_set     <= mem_raddr;
            r_tag     <= sac_lru_pkg::TAG_W'(i_address >>
                                             (sac_lru_pkg::OFF_W + sac_lru_pkg::SET_W));
            r_stamp   <= i_time_stamp;
        end
        if (look_fire) begin
            r_miss <= !hit;
            r_way  <= sac_lru_pkg::WAY_OUT_W'(sel_way);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_miss            = r_miss;
    assign o_way_used        = r_way;
    assign o_hit_total       = r_hit_cnt;
    assign o_miss_total      = r_miss_cnt;
    assign o_load_hit_total  = r_ld_hit_cnt;
    assign o_load_miss_total = r_ld_miss_cnt;

endmodule

`default_nettype wire

// ===== design/sac_lru_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sac_lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sac_lru_chk.sv =====
// Port-level checker for set_assoc_cache_lru_lookup_unit, bound to the top level.
// Depends on the top level's port names only.
`timescale 1ns / 1ps
`default_nettype none

module sac_lru_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_miss,
    input wire logic [3:0]  o_way_used,
    input wire logic [31:0] o_hit_total,
    input wire logic [31:0] o_miss_total
);

    logic r_prev_valid;
    logic r_prev_stall;
    logic new_beat;

    always_ff @(posedge i_clk) begin
        r_prev_valid <= o_valid;
        r_prev_stall <= i_stall;
    end

    // a fresh result shows when the register was empty or its beat was just taken
    assign new_beat = o_valid && (!r_prev_valid || !r_prev_stall);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_miss) && $stable(o_way_used)
                                  && $stable(o_hit_total) && $stable(o_miss_total)))
        else $error("stalled result beat changed");

    // one beat in flight: input side busy right after a beat is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while a beat is in flight");

    // a fresh hit bumps the hit count and leaves the miss count
    a_hit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && new_beat && !o_miss && ($past(o_hit_total) != 32'hFFFF_FFFF))
        |-> ((o_hit_total == $past(o_hit_total) + 32'd1)
             && (o_miss_total == $past(o_miss_total))))
        else $error("hit count out of step");

    // a fresh miss bumps the miss count and leaves the hit count
    a_miss_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && new_beat && o_miss && ($past(o_miss_total) != 32'hFFFF_FFFF))
        |-> ((o_miss_total == $past(o_miss_total) + 32'd1)
             && (o_hit_total == $past(o_hit_total))))
        else $error("miss count out of step");

endmodule

bind set_assoc_cache_lru_lookup_unit sac_lru_chk u_sac_lru_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_miss       (o_miss),
    .o_way_used   (o_way_used),
    .o_hit_total  (o_hit_total),
    .o_miss_total (o_miss_total)
);

`default_nettype wire
